// File: rtl/core/lrbf_pkg.sv
package lrbf_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int SQRT_STEPS    = 32;
   localparam int CORDIC_W      = 36;

   localparam logic [7:0]  CSR_SENSOR_RANGE   = 8'd0;
   localparam logic [7:0]  CSR_HALF_FOV       = 8'd1;
   localparam logic [30:0] SENSOR_RANGE_RESET = 31'd1966080;
   localparam logic [15:0] HALF_FOV_RESET     = 16'd13107;
   localparam logic [31:0] HALF_TURN          = 32'h8000_0000;
   localparam logic [31:0] ROUND_HALF         = 32'h0000_8000;

   typedef struct packed {
      logic signed [31:0] robot_x;
      logic signed [31:0] robot_y;
      logic [15:0]        robot_heading;
      logic signed [31:0] landmark_x;
      logic signed [31:0] landmark_y;
      logic [15:0]        landmark_tag;
   } req_type;

   typedef struct packed {
      logic [15:0]        tag_out;
      logic               visible;
      logic [31:0]        distance;
      logic signed [15:0] bearing;
   } rsp_type;

   // Per-beat context carried down the pipeline next to the range path.
   typedef struct packed {
      logic [15:0]                heading;
      logic [15:0]                tag;
      logic                       zero;
      logic signed [CORDIC_W-1:0] cx;
      logic signed [CORDIC_W-1:0] cy;
      logic [31:0]                cz;
   } ctx_type;

   // Arctangent of 2^-i in units of 2^-32 turn, rounded to nearest.
   function automatic logic [31:0] atan_turn32(input int idx);
      logic [31:0] val;
      case (idx)
         0:  val = 32'd536870912;
         1:  val = 32'd316933406;
         2:  val = 32'd167458907;
         3:  val = 32'd85004756;
         4:  val = 32'd42667331;
         5:  val = 32'd21354465;
         6:  val = 32'd10679838;
         7:  val = 32'd5340245;
         8:  val = 32'd2670163;
         9:  val = 32'd1335087;
         10: val = 32'd667544;
         11: val = 32'd333772;
         12: val = 32'd166886;
         13: val = 32'd83443;
         14: val = 32'd41722;
         15: val = 32'd20861;
         16: val = 32'd10430;
         17: val = 32'd5215;
         18: val = 32'd2608;
         19: val = 32'd1304;
         20: val = 32'd652;
         21: val = 32'd326;
         22: val = 32'd163;
         23: val = 32'd81;
         24: val = 32'd41;
         25: val = 32'd20;
         26: val = 32'd10;
         27: val = 32'd5;
         28: val = 32'd3;
         29: val = 32'd1;
         30: val = 32'd1;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

// File: rtl/core/landmark_range_bearing_filter.sv
// Landmark range and bearing check, fully pipelined.
// Input channel: a beat (robot pose plus one landmark) is taken on a rising
// edge with start high and busy low. Busy stays low, so a new beat may be
// issued in every cycle.
// Result channel: rsp_valid rises with rsp_data once the beat has passed stages
// A to D, the square-root stages, stage F and the output register, stays high for
// exactly one cycle, and the result is taken in that cycle. Results come in issue order.
// Throughput is one beat per cycle. The pipeline is built around the 32-stage
// restoring square root, one result bit per stage, which carries the CORDIC
// vectoring stages beside it, after four front stages (difference, magnitude,
// squares, sum) and before two back stages (bearing, visibility compare).
// Configuration: csr_valid/csr_ready writes csr_wdata into register
// csr_index (0 is sensor range, 1 is half field of view); other indexes
// are ignored. Write only while no beat is in flight.
// Reset clears every valid bit in the pipeline and loads the register
// defaults of 30 m and one fifth of a turn. The receiver cannot stall.
module landmark_range_bearing_filter
   import lrbf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic [30:0] sensor_range_ff, sensor_range_in;
   logic [15:0] half_fov_ff, half_fov_in;

   logic               a_valid_ff, a_valid_in;
   logic signed [32:0] a_dx_ff, a_dx_in;
   logic signed [32:0] a_dy_ff, a_dy_in;
   logic [15:0]        a_heading_ff, a_tag_ff;

   logic        b_valid_ff;
   ctx_type     b_ctx_ff, b_ctx_in;
   logic [31:0] b_ax_ff, b_ax_in, b_ay_ff, b_ay_in;
   logic [32:0] b_negx, b_negy;

   logic        c_valid_ff;
   ctx_type     c_ctx_ff;
   logic [63:0] c_sqx_ff, c_sqx_in, c_sqy_ff, c_sqy_in;

   logic        d_valid_ff;
   ctx_type     d_ctx_ff;
   logic        d_ovf_ff, d_ovf_in;
   logic [63:0] d_rem_ff, d_rem_in;

   logic        lp_valid_ff [SQRT_STEPS];
   ctx_type     lp_ctx_ff   [SQRT_STEPS];
   logic        lp_ovf_ff   [SQRT_STEPS];
   logic [63:0] lp_rem_ff   [SQRT_STEPS];
   logic [63:0] lp_root_ff  [SQRT_STEPS];

   logic        f_valid_ff;
   logic [15:0] f_tag_ff;
   logic [31:0] f_dist_ff, f_dist_in;
   logic [15:0] f_bear_ff, f_bear_in;
   logic [31:0] f_round;

   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic [15:0] o_mag;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      sensor_range_in = sensor_range_ff;
      half_fov_in     = half_fov_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SENSOR_RANGE: sensor_range_in = csr_wdata[30:0];
            CSR_HALF_FOV:     half_fov_in     = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_range_ff <= SENSOR_RANGE_RESET;
         half_fov_ff     <= HALF_FOV_RESET;
      end else begin
         sensor_range_ff <= sensor_range_in;
         half_fov_ff     <= half_fov_in;
      end
   end

   // Stage A: coordinate differences, exact in 33 bits.
   assign a_valid_in = start && !busy;
   assign a_dx_in = $signed({req_data.landmark_x[31], req_data.landmark_x})
                  - $signed({req_data.robot_x[31], req_data.robot_x});
   assign a_dy_in = $signed({req_data.landmark_y[31], req_data.landmark_y})
                  - $signed({req_data.robot_y[31], req_data.robot_y});

   always_ff @(posedge clock) begin
      a_dx_ff      <= a_dx_in;
      a_dy_ff      <= a_dy_in;
      a_heading_ff <= req_data.robot_heading;
      a_tag_ff     <= req_data.landmark_tag;
   end

   // Stage B: magnitudes for the range path and the CORDIC half-turn fold.
   assign b_negx = 33'(-a_dx_ff);
   assign b_negy = 33'(-a_dy_ff);

   always_comb begin
      b_ax_in          = a_dx_ff[32] ? b_negx[31:0] : a_dx_ff[31:0];
      b_ay_in          = a_dy_ff[32] ? b_negy[31:0] : a_dy_ff[31:0];
      b_ctx_in.heading = a_heading_ff;
      b_ctx_in.tag     = a_tag_ff;
      b_ctx_in.zero    = (a_dx_ff == '0) && (a_dy_ff == '0);
      if (a_dx_ff[32]) begin
         b_ctx_in.cx = CORDIC_W'($signed(b_negx));
         b_ctx_in.cy = CORDIC_W'($signed(b_negy));
         b_ctx_in.cz = HALF_TURN;
      end else begin
         b_ctx_in.cx = CORDIC_W'(a_dx_ff);
         b_ctx_in.cy = CORDIC_W'(a_dy_ff);
         b_ctx_in.cz = '0;
      end
   end

   always_ff @(posedge clock) begin
      b_ctx_ff <= b_ctx_in;
      b_ax_ff  <= b_ax_in;
      b_ay_ff  <= b_ay_in;
   end

   // Stage C: squares.
   assign c_sqx_in = 64'(b_ax_ff) * 64'(b_ax_ff);
   assign c_sqy_in = 64'(b_ay_ff) * 64'(b_ay_ff);

   always_ff @(posedge clock) begin
      c_ctx_ff <= b_ctx_ff;
      c_sqx_ff <= c_sqx_in;
      c_sqy_ff <= c_sqy_in;
   end

   // Stage D: sum of squares with overflow flag.
   assign {d_ovf_in, d_rem_in} = {1'b0, c_sqx_ff} + {1'b0, c_sqy_ff};

   always_ff @(posedge clock) begin
      d_ctx_ff <= c_ctx_ff;
      d_ovf_ff <= d_ovf_in;
      d_rem_ff <= d_rem_in;
   end

   // Main pipeline: one square root bit per stage, and one CORDIC rotation in each of the first CORDIC_STAGES stages.
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam logic [63:0] SqBit = 64'd1 << (62 - 2 * k);

      logic                       prv_valid;
      ctx_type                    prv_ctx;
      logic                       prv_ovf;
      logic [63:0]                prv_rem, prv_root;
      logic [63:0]                trial;
      ctx_type                    ctx_in;
      logic [63:0]                rem_in, root_in;
      logic signed [CORDIC_W-1:0] px, py, xs, ys;

      if (k == 0) begin : g_first
         assign prv_valid = d_valid_ff;
         assign prv_ctx   = d_ctx_ff;
         assign prv_ovf   = d_ovf_ff;
         assign prv_rem   = d_rem_ff;
         assign prv_root  = '0;
      end else begin : g_next
         assign prv_valid = lp_valid_ff[k-1];
         assign prv_ctx   = lp_ctx_ff[k-1];
         assign prv_ovf   = lp_ovf_ff[k-1];
         assign prv_rem   = lp_rem_ff[k-1];
         assign prv_root  = lp_root_ff[k-1];
      end

      assign trial = prv_root + SqBit;
      assign px    = prv_ctx.cx;
      assign py    = prv_ctx.cy;
      assign xs    = px >>> k;
      assign ys    = py >>> k;

      always_comb begin
         if (prv_rem >= trial) begin
            rem_in  = prv_rem - trial;
            root_in = (prv_root >> 1) + SqBit;
         end else begin
            rem_in  = prv_rem;
            root_in = prv_root >> 1;
         end
         ctx_in = prv_ctx;
         if (k < CORDIC_STAGES) begin
            if (py > 0) begin
               ctx_in.cx = px + ys;
               ctx_in.cy = py - xs;
               ctx_in.cz = prv_ctx.cz + atan_turn32(k);
            end else begin
               ctx_in.cx = px - ys;
               ctx_in.cy = py + xs;
               ctx_in.cz = prv_ctx.cz - atan_turn32(k);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            lp_valid_ff[k] <= 1'b0;
         end else begin
            lp_valid_ff[k] <= prv_valid;
         end
      end

      always_ff @(posedge clock) begin
         lp_ctx_ff[k]  <= ctx_in;
         lp_ovf_ff[k]  <= prv_ovf;
         lp_rem_ff[k]  <= rem_in;
         lp_root_ff[k] <= root_in;
      end
   end

   // Stage F: saturated distance and relative bearing.
   assign f_round   = lp_ctx_ff[SQRT_STEPS-1].cz + ROUND_HALF;
   assign f_dist_in = lp_ovf_ff[SQRT_STEPS-1] ? '1 : lp_root_ff[SQRT_STEPS-1][31:0];
   assign f_bear_in = lp_ctx_ff[SQRT_STEPS-1].zero ? '0
                    : f_round[31:16] - lp_ctx_ff[SQRT_STEPS-1].heading;

   always_ff @(posedge clock) begin
      f_tag_ff  <= lp_ctx_ff[SQRT_STEPS-1].tag;
      f_dist_ff <= f_dist_in;
      f_bear_ff <= f_bear_in;
   end

   // Output stage: visibility compare.
   assign o_mag = f_bear_ff[15] ? 16'(~f_bear_ff + 16'd1) : f_bear_ff;

   always_comb begin
      rsp_data_in.tag_out  = f_tag_ff;
      rsp_data_in.distance = f_dist_ff;
      rsp_data_in.bearing  = f_bear_ff;
      rsp_data_in.visible  = (f_dist_ff < {1'b0, sensor_range_ff}) && (o_mag < half_fov_ff);
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         f_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         d_valid_ff   <= c_valid_ff;
         f_valid_ff   <= lp_valid_ff[SQRT_STEPS-1];
         rsp_valid_ff <= f_valid_ff;
      end
   end

endmodule

// File: bench/lrbf_sight_checker.sv
`timescale 1ns / 100ps

module lrbf_sight_checker
   import lrbf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  rsp_type     rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int unsigned mismatches,
   output int unsigned outstanding
);

   logic [31:0] atan_step [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
   };

   logic [30:0] range_limit;
   logic [15:0] half_fov;
   rsp_type     sightings_due [$];
   rsp_type     want;

   function automatic rsp_type sight_landmark(input req_type beat);
      longint      dx, dy, cx, cy, sx, sy;
      logic [65:0] ax, ay, sq_sum;
      logic [63:0] rem, root, probe;
      logic [31:0] turn, rounded;
      logic [15:0] rel;
      logic [16:0] mag;
      rsp_type     sight;
      dx = longint'(beat.landmark_x) - longint'(beat.robot_x);
      dy = longint'(beat.landmark_y) - longint'(beat.robot_y);
      ax = 66'(dx < 0 ? -dx : dx);
      ay = 66'(dy < 0 ? -dy : dy);
      sq_sum = ax * ax + ay * ay;
      if (sq_sum[65:64] != 2'b00) begin
         sight.distance = 32'hFFFF_FFFF;
      end else begin
         rem = sq_sum[63:0];
         root = '0;
         probe = 64'h1 << 62;
         while (probe > rem) probe = probe >> 2;
         while (probe != 0) begin
            if (rem >= root + probe) begin
               rem = rem - (root + probe);
               root = (root >> 1) + probe;
            end else begin
               root = root >> 1;
            end
            probe = probe >> 2;
         end
         sight.distance = root[31:0];
      end
      if (dx == 0 && dy == 0) begin
         rel = '0;
      end else begin
         cx = dx;
         cy = dy;
         turn = '0;
         if (cx < 0) begin
            cx = -cx;
            cy = -cy;
            turn = HALF_TURN;
         end
         for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            sx = cx >>> i;
            sy = cy >>> i;
            if (cy > 0) begin
               cx = cx + sy;
               cy = cy - sx;
               turn = turn + atan_step[i];
            end else begin
               cx = cx - sy;
               cy = cy + sx;
               turn = turn - atan_step[i];
            end
         end
         rounded = turn + ROUND_HALF;
         rel = rounded[31:16] - beat.robot_heading;
      end
      mag = rel[15] ? (17'h10000 - {1'b0, rel}) : {1'b0, rel};
      sight.tag_out = beat.landmark_tag;
      sight.bearing = rel;
      sight.visible = (sight.distance < {1'b0, range_limit}) && (mag < {1'b0, half_fov});
      return sight;
   endfunction

   task automatic note_fault(input string msg);
      if (mismatches < 100) $display("lrbf check: %s", msg);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         range_limit = SENSOR_RANGE_RESET;
         half_fov = HALF_FOV_RESET;
         sightings_due.delete();
         mismatches = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SENSOR_RANGE: range_limit = csr_wdata[30:0];
               CSR_HALF_FOV:     half_fov = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (start && !busy)
            sightings_due.insert(sightings_due.size(), sight_landmark(req_data));
         if (rsp_valid) begin
            if (sightings_due.size() == 0) begin
               note_fault($sformatf("result beat with tag %0d arrived with nothing expected",
                  rsp_data.tag_out));
            end else begin
               want = sightings_due.pop_front();
               if (rsp_data.tag_out !== want.tag_out)
                  note_fault($sformatf("tag_out got %0d expected %0d",
                     rsp_data.tag_out, want.tag_out));
               if (rsp_data.visible !== want.visible)
                  note_fault($sformatf("tag %0d visible got %0b expected %0b",
                     want.tag_out, rsp_data.visible, want.visible));
               if (rsp_data.distance !== want.distance)
                  note_fault($sformatf("tag %0d distance got %0d expected %0d",
                     want.tag_out, rsp_data.distance, want.distance));
               if (rsp_data.bearing !== want.bearing)
                  note_fault($sformatf("tag %0d bearing got %0d expected %0d",
                     want.tag_out, rsp_data.bearing, want.bearing));
            end
         end
      end
      outstanding = sightings_due.size();
   end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top
   import lrbf_pkg::*;
();

   localparam int          CYCLE_LIMIT   = 200000;
   localparam int          SETTLE_CYCLES = 50;
   localparam int          METER         = 65536;
   localparam logic [7:0]  CSR_UNMAPPED  = 8'hFF;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_index;
   logic [31:0] csr_wdata;
   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned cycles = 0;
   bit          gaps_on;

   landmark_range_bearing_filter u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lrbf_sight_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("landmark_range_bearing_filter verification failed");
         $finish;
      end
   end

   function automatic req_type pose_beat(input int rx, input int ry, input logic [15:0] hd,
                                         input int lx, input int ly, input logic [15:0] tag);
      req_type beat;
      beat.robot_x = rx;
      beat.robot_y = ry;
      beat.robot_heading = hd;
      beat.landmark_x = lx;
      beat.landmark_y = ly;
      beat.landmark_tag = tag;
      return beat;
   endfunction

   // Two in five landmarks land near the default sensor range so that visibility splits both ways.
   function automatic req_type roll_beat();
      req_type     beat;
      int unsigned pick;
      int          off_x, off_y;
      beat.robot_x = $urandom;
      beat.robot_y = $urandom;
      beat.robot_heading = $urandom;
      beat.landmark_tag = $urandom;
      off_x = int'($urandom_range(0, 4194304)) - 2097152;
      off_y = int'($urandom_range(0, 4194304)) - 2097152;
      pick = $urandom_range(99);
      if (pick >= 40 && pick < 60) begin
         off_x = int'($urandom_range(0, 268435456)) - 134217728;
         off_y = int'($urandom_range(0, 268435456)) - 134217728;
      end else if (pick >= 60 && pick < 85) begin
         off_x = $urandom;
         off_y = $urandom;
      end else if (pick >= 85) begin
         case ($urandom_range(3))
            0: begin
               off_x = 0;
               off_y = 0;
            end
            1: off_x = 0;
            2: off_y = 0;
            default: off_y = $urandom_range(1) ? off_x : -off_x;
         endcase
      end
      beat.landmark_x = beat.robot_x + off_x;
      beat.landmark_y = beat.robot_y + off_y;
      return beat;
   endfunction

   task automatic issue_beat(input req_type beat);
      @(negedge clock);
      while (gaps_on && $urandom_range(99) < 8) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (busy);
   endtask

   task automatic run_random(input int count);
      repeat (count) issue_beat(roll_beat());
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [7:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      gaps_on = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      issue_beat(pose_beat(0, 0, 16'h0000, 0, 0, 16'h0000));
      issue_beat(pose_beat(32'sh8000_0000, 32'sh8000_0000, 16'hFFFF,
                           32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF));
      issue_beat(pose_beat(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'h8000,
                           32'sh8000_0000, 32'sh8000_0000, 16'h0001));
      issue_beat(pose_beat(32'sh8000_0000, 0, 16'h0000, 32'sh7FFF_FFFF, 0, 16'h0002));
      issue_beat(pose_beat(METER, -METER, 16'h0000, METER + 1966080, -METER, 16'h0003));
      issue_beat(pose_beat(METER, -METER, 16'h0000, METER + 1966079, -METER, 16'h0004));
      issue_beat(pose_beat(0, 0, 16'h0000, -10 * METER, 0, 16'h0005));
      issue_beat(pose_beat(0, 0, 16'h8000, 10 * METER, 0, 16'h0006));
      issue_beat(pose_beat(0, 0, 16'd52429, 5 * METER, 0, 16'h0007));
      issue_beat(pose_beat(0, 0, 16'd13107, 5 * METER, 0, 16'h0008));
      issue_beat(pose_beat(0, 0, 16'd52430, 5 * METER, 0, 16'h0009));
      issue_beat(pose_beat(0, 0, 16'd13106, 5 * METER, 0, 16'h000A));
      issue_beat(pose_beat(0, 0, 16'd52428, 5 * METER, 0, 16'h000B));
      issue_beat(pose_beat(0, 0, 16'd13108, 5 * METER, 0, 16'h000C));
      issue_beat(pose_beat(2 * METER, 2 * METER, 16'h0000, 5 * METER, 6 * METER, 16'h5555));
      issue_beat(pose_beat(2 * METER, 2 * METER, 16'h4000, -METER, 6 * METER, 16'hAAAA));
      issue_beat(pose_beat(2 * METER, 2 * METER, 16'hC000, -METER, -2 * METER, 16'h00FF));
      issue_beat(pose_beat(2 * METER, 2 * METER, 16'h2000, 5 * METER, -2 * METER, 16'hFF00));
      issue_beat(pose_beat(0, 0, 16'h4000, 0, 7 * METER, 16'h0010));
      issue_beat(pose_beat(0, 0, 16'hC000, 0, -7 * METER, 16'h0011));
      issue_beat(pose_beat(100, 100, 16'h0000, 101, 100, 16'h0012));
      issue_beat(pose_beat(100, 100, 16'h0000, 100, 99, 16'h0013));
      issue_beat(pose_beat(100, 100, 16'h0000, 99, 99, 16'h0014));
      issue_beat(pose_beat(32'sh1234_5678, -32'sh0765_4321, 16'h1357,
                           32'sh1234_5678, -32'sh0765_4321, 16'h0015));

      drain();
      write_csr(CSR_SENSOR_RANGE, 32'h0000_0000);
      write_csr(CSR_HALF_FOV, 32'h0000_0000);
      write_csr(CSR_UNMAPPED, 32'hFFFF_FFFF);
      issue_beat(pose_beat(0, 0, 16'h0000, 0, 0, 16'h0020));
      issue_beat(pose_beat(0, 0, 16'h0000, METER, 0, 16'h0021));
      run_random(60);

      drain();
      write_csr(CSR_SENSOR_RANGE, 32'hFFFF_FFFF);
      write_csr(CSR_HALF_FOV, 32'd32768);
      issue_beat(pose_beat(0, 0, 16'h0000, -10 * METER, 0, 16'h0030));
      issue_beat(pose_beat(0, 0, 16'h8000, 10 * METER, 0, 16'h0031));
      run_random(80);

      drain();
      write_csr(CSR_HALF_FOV, 32'hFFFF_FFFF);
      issue_beat(pose_beat(0, 0, 16'h0000, -10 * METER, 0, 16'h0040));
      run_random(40);

      for (int phase = 0; phase < 5; phase++) begin
         drain();
         write_csr(CSR_SENSOR_RANGE, ($urandom_range(3) == 0) ? $urandom
                                                              : $urandom_range(0, 4000000));
         write_csr(CSR_HALF_FOV, ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 32768));
         gaps_on = (phase != 2);
         run_random(45);
         if (phase == 1) drain();
         run_random(45);
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("landmark_range_bearing_filter verification clean");
      end else begin
         $display("landmark_range_bearing_filter verification failed");
      end
      $finish;
   end

endmodule
